[hw/rtl/gnse_pkg.sv]
// Shared types and constants for the gate netlist stream evaluator.
// Used by the parser front end, the command queue and the evaluation back end.
package gnse_pkg;

	localparam int WidthW    = 7;   // level width field, 1..64
	localparam int IdxW      = 6;   // operand bit index
	localparam int QDepth    = 4;   // command queue entries
	localparam int OutDataW  = 104; // level_bits, level_index, status, zero pad

	localparam logic [7:0] GATE_TYPES = 8'h0e;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_BAD_WIDTH = 2'd1;
	localparam logic [1:0] ST_BAD_TYPE  = 2'd2;
	localparam logic [1:0] ST_BAD_INDEX = 2'd3;

	typedef enum logic [1:0] {
		CK_LOAD,    // width accepted: load level 0 input
		CK_OPND,    // one operand of a gate
		CK_FAIL     // parse error, report and stop
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [IdxW-1:0]   idx;
		logic [1:0]        slot;
		logic [3:0]        gtype;
		logic [IdxW-1:0]   gpos;
		logic              gate_done;
		logic              level_end;
		logic              last_level;
		logic [1:0]        code;
	} cmd_t;

endpackage

[hw/rtl/gnse_front.sv]
// Byte parser: header skip, 64-bit field assembly, gate record decode.
// Emits at most one command word per byte (width load, operand or error); uses gnse_pkg.
module gnse_front #(
	parameter int MAX_WIDTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic [7:0]    data_byte,
	input  logic          start_of_file,
	output logic          cmd_valid,
	output gnse_pkg::cmd_t cmd
);
	import gnse_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER, PH_WIDTH, PH_COUNT, PH_SKIP_A, PH_SKIP_B, PH_TYPE, PH_OPERAND, PH_IDLE
	} phase_t;

	phase_t            ph_q, ph_e, ph_n;
	logic              halt_q, halt_e, halt_n;
	logic [2:0]        bc_q, bc_e, bc_n;
	logic [55:0]       acc_q;
	logic [WidthW-1:0] wid_q, wid_n;
	logic [63:0]       rem_q, rem_n;
	logic [3:0]        type_q, type_n;
	logic [1:0]        opl_q, opl_n;
	logic [1:0]        slot_q, slot_n;
	logic [IdxW-1:0]   gpos_q, gpos_e, gpos_n;
	logic [63:0]       v;
	logic [WidthW-1:0] gpos_inc;
	logic              gate_last, lend, fin;

	function automatic logic [1:0] op_count(input logic [3:0] t);
		if (t == 4'd0) return 2'd1;
		else if (t <= 4'd6) return 2'd2;
		else return 2'd3;
	endfunction

	// a start mark clears parse state; the byte itself is header byte 0
	assign ph_e   = start_of_file ? PH_HEADER : ph_q;
	assign halt_e = start_of_file ? 1'b0 : halt_q;
	assign bc_e   = start_of_file ? 3'd0 : bc_q;
	assign gpos_e = start_of_file ? '0 : gpos_q;

	assign v         = {data_byte, acc_q};
	assign gpos_inc  = WidthW'(gpos_e) + WidthW'(1);
	assign gate_last = (opl_q == 2'd1);
	assign lend      = gate_last && (gpos_inc == wid_q);
	assign fin       = (rem_q <= 64'(wid_q));

	always_comb begin
		ph_n      = ph_e;
		halt_n    = halt_e;
		bc_n      = bc_e;
		wid_n     = wid_q;
		rem_n     = rem_q;
		type_n    = type_q;
		opl_n     = opl_q;
		slot_n    = slot_q;
		gpos_n    = gpos_e;
		cmd_valid = 1'b0;
		cmd       = '0;
		cmd.kind  = CK_OPND;
		if (!halt_e && ph_e != PH_IDLE) begin
			unique case (ph_e)
				PH_HEADER: begin
					bc_n = bc_e + 3'd1;
					if (bc_e == 3'd3) begin
						ph_n = PH_WIDTH;
						bc_n = 3'd0;
					end
				end
				PH_TYPE: begin
					if (data_byte >= GATE_TYPES) begin
						halt_n    = 1'b1;
						cmd_valid = 1'b1;
						cmd.kind  = CK_FAIL;
						cmd.code  = ST_BAD_TYPE;
					end else begin
						type_n = data_byte[3:0];
						opl_n  = op_count(data_byte[3:0]);
						slot_n = 2'd0;
						ph_n   = PH_OPERAND;
						bc_n   = 3'd0;
					end
				end
				default: begin
					bc_n = bc_e + 3'd1;
					if (bc_e == 3'd7) begin
						unique case (ph_e)
							PH_WIDTH: begin
								if (v == 64'd0 || v > 64'(MAX_WIDTH)) begin
									halt_n    = 1'b1;
									cmd_valid = 1'b1;
									cmd.kind  = CK_FAIL;
									cmd.code  = ST_BAD_WIDTH;
								end else begin
									wid_n     = v[WidthW-1:0];
									ph_n      = PH_COUNT;
									cmd_valid = 1'b1;
									cmd.kind  = CK_LOAD;
								end
							end
							PH_COUNT: begin
								// raw count; a level is whole while at least width remain
								rem_n = v;
								ph_n  = PH_SKIP_A;
							end
							PH_SKIP_A: ph_n = PH_SKIP_B;
							PH_SKIP_B: ph_n = (rem_q < 64'(wid_q)) ? PH_IDLE : PH_TYPE;
							PH_OPERAND: begin
								if (v[63:WidthW] != '0 || v[WidthW-1:0] >= wid_q) begin
									halt_n    = 1'b1;
									cmd_valid = 1'b1;
									cmd.kind  = CK_FAIL;
									cmd.code  = ST_BAD_INDEX;
								end else begin
									cmd_valid      = 1'b1;
									cmd.kind       = CK_OPND;
									cmd.idx        = v[IdxW-1:0];
									cmd.slot       = slot_q;
									cmd.gtype      = type_q;
									cmd.gpos       = gpos_e;
									cmd.gate_done  = gate_last;
									cmd.level_end  = lend;
									cmd.last_level = fin;
									opl_n          = opl_q - 2'd1;
									slot_n         = slot_q + 2'd1;
									if (gate_last) begin
										rem_n  = rem_q - 64'd1;
										gpos_n = lend ? '0 : gpos_inc[IdxW-1:0];
										ph_n   = (lend && fin) ? PH_IDLE : PH_TYPE;
									end
								end
							end
							default: ;
						endcase
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_HEADER;
			halt_q <= 1'b0;
			bc_q   <= 3'd0;
			wid_q  <= '0;
			rem_q  <= '0;
			type_q <= '0;
			opl_q  <= '0;
			slot_q <= '0;
			gpos_q <= '0;
		end else if (fire) begin
			ph_q   <= ph_n;
			halt_q <= halt_n;
			bc_q   <= bc_n;
			wid_q  <= wid_n;
			rem_q  <= rem_n;
			type_q <= type_n;
			opl_q  <= opl_n;
			slot_q <= slot_n;
			gpos_q <= gpos_n;
		end
	end

	// bytes land at their own lane; the top byte is taken straight from the input
	always_ff @(posedge clk) begin
		if (fire && bc_e != 3'd7) begin
			acc_q[{bc_e, 3'b000} +: 8] <= data_byte;
		end
	end

endmodule

[hw/rtl/gnse_fifo.sv]
// Short command queue between parser and evaluator.
// Flop-based, QDepth entries of gnse_pkg::cmd_t.
module gnse_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gnse_pkg::cmd_t push_data,
	output logic           full,
	output logic           pop_valid,
	input  logic           pop,
	output gnse_pkg::cmd_t pop_data
);
	import gnse_pkg::*;

	localparam int PW = $clog2(QDepth);

	cmd_t           mem_q [QDepth];
	logic [PW-1:0]  wp_q, rp_q;
	logic [PW:0]    cnt_q;
	logic           do_push, do_pop;

	assign full      = (cnt_q == (PW+1)'(QDepth));
	assign pop_valid = (cnt_q != '0);
	assign pop_data  = mem_q[rp_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + PW'(1);
			if (do_pop)  rp_q <= rp_q + PW'(1);
			if (do_push && !do_pop)      cnt_q <= cnt_q + (PW+1)'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - (PW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= push_data;
	end

endmodule

[hw/rtl/gnse_back.sv]
// Evaluator: double-buffered level vectors, gate logic, level counter, output register.
// Consumes gnse_pkg::cmd_t words from the queue.
module gnse_back #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [63:0]                   initial_bits,
	input  logic                          cmd_valid,
	input  gnse_pkg::cmd_t                cmd,
	output logic                          cmd_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gnse_pkg::OutDataW-1:0] out_data,
	output logic                          out_last
);
	import gnse_pkg::*;

	localparam int IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [MAX_WIDTH-1:0] prev_q, bld_q, bld_new, gate_mask;
	logic [2:0]           ops_q, ops_now;
	logic [31:0]          lvl_q;
	logic                 emit, out_free, go, bit_in, gv;

	function automatic logic gate_value(input logic [3:0] t, input logic [2:0] o);
		logic a, b, c;
		a = o[0];
		b = o[1];
		c = o[2];
		unique case (t)
			4'd0:    return ~a;
			4'd1:    return a & b;
			4'd2:    return a | b;
			4'd3:    return a ^ b;
			4'd4:    return ~(a & b);
			4'd5:    return ~(a | b);
			4'd6:    return ~(a ^ b);
			4'd7:    return a & b & c;
			4'd8:    return a | b | c;
			4'd9:    return ~(a & b & c);
			4'd10:   return ~(a | b | c);
			4'd11:   return a ^ b ^ c;
			4'd12:   return ~(a ^ b ^ c);
			default: return a ? b : c;
		endcase
	endfunction

	assign emit     = (cmd.kind == CK_FAIL) || (cmd.kind == CK_OPND && cmd.level_end);
	assign out_free = !out_valid || out_ready;
	assign go       = cmd_valid && (out_free || !emit);
	assign cmd_pop  = go;

	assign bit_in    = prev_q[cmd.idx[IW-1:0]];
	assign ops_now   = ((cmd.slot == 2'd0) ? 3'b000 : ops_q) | (3'(bit_in) << cmd.slot);
	assign gv        = gate_value(cmd.gtype, ops_now);
	assign gate_mask = MAX_WIDTH'(gv) << cmd.gpos[IW-1:0];
	assign bld_new   = bld_q | gate_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			bld_q     <= '0;
			ops_q     <= '0;
			lvl_q     <= '0;
			out_valid <= 1'b0;
			out_data  <= '0;
			out_last  <= 1'b0;
		end else begin
			if (out_ready) out_valid <= 1'b0;
			if (go) begin
				unique case (cmd.kind)
					CK_LOAD: begin
						prev_q <= initial_bits[MAX_WIDTH-1:0];
						bld_q  <= '0;
						lvl_q  <= '0;
					end
					CK_OPND: begin
						ops_q <= ops_now;
						if (cmd.gate_done) begin
							if (cmd.level_end) begin
								prev_q    <= bld_new;
								bld_q     <= '0;
								if (lvl_q != 32'hffff_ffff) lvl_q <= lvl_q + 32'd1;
								out_valid <= 1'b1;
								out_last  <= cmd.last_level;
								out_data  <= {6'd0, ST_DONE, lvl_q, 64'(bld_new)};
							end else begin
								bld_q <= bld_new;
							end
						end
					end
					CK_FAIL: begin
						// a width error comes before any level, so its index is zero
						out_valid <= 1'b1;
						out_last  <= 1'b1;
						out_data  <= {6'd0, cmd.code,
							(cmd.code == ST_BAD_WIDTH) ? 32'd0 : lvl_q, 64'd0};
					end
					default: ;
				endcase
			end
		end
	end

endmodule

[hw/rtl/gate_netlist_stream_evaluator_unit.sv]
// Gate netlist stream evaluator: one netlist file byte per word, one level vector out.
// Path of a result word from the byte that completes it:
// parser to queue register, then evaluator to output register.
// Throughput: 1 byte per cycle while the command queue is not full.
// Reset clears parse state, level buffers, counters and initial_bits; no clearing pass.
// Uses gnse_pkg, gnse_front, gnse_fifo and gnse_back.
module gate_netlist_stream_evaluator_unit #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] data_byte
	input  logic [0:0]                    s_tuser,   // [0] start_of_file
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [63:0] level_bits, [95:64] level_index, [97:96] status, [103:98] zero
	output logic [gnse_pkg::OutDataW-1:0] m_tdata,
	output logic                          m_tlast,   // final_level
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [63:0]                   cfg_data
);
	import gnse_pkg::*;

	logic        fire, q_full, f_cmd_valid, q_valid, q_pop;
	cmd_t        f_cmd, q_cmd;
	logic [63:0] init_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign fire      = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) init_q <= '0;
		else if (cfg_valid) init_q <= cfg_data;
	end

	gnse_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.data_byte     (s_tdata),
		.start_of_file (s_tuser[0]),
		.cmd_valid     (f_cmd_valid),
		.cmd           (f_cmd)
	);

	gnse_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire && f_cmd_valid),
		.push_data (f_cmd),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_data  (q_cmd)
	);

	gnse_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.initial_bits (init_q),
		.cmd_valid    (q_valid),
		.cmd          (q_cmd),
		.cmd_pop      (q_pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_data     (m_tdata),
		.out_last     (m_tlast)
	);

endmodule
